// ----- hdl/psq_pkg.sv -----
// Shared types and constants of the priority sorted wait queue.
// Used by psq_ctrl, psq_datapath and priority_sorted_wait_queue; depends on nothing.
package psq_pkg;

	localparam int DEF_QUEUE_DEPTH    = 16;
	localparam int DEF_THREAD_ID_BITS = 8;

	localparam logic [1:0] OP_ADD     = 2'd0;
	localparam logic [1:0] OP_REMOVE  = 2'd1;
	localparam logic [1:0] OP_REQUEUE = 2'd2;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_ALREADY    = 2'd1,
		STATUS_NOT_QUEUED = 2'd2,
		STATUS_FULL       = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_REINS
	} state_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] thread_id;
		logic [7:0] priority_req;
	} req_t;

	typedef struct packed {
		status_t    status;
		logic       head_valid;
		logic [7:0] head_thread;
		logic [7:0] head_priority;
		logic [4:0] entry_count;
	} rsp_t;

	typedef struct packed {
		logic    load;
		logic    remove;
		logic    insert;
		logic    set_status;
		status_t status;
	} cmd_t;

	typedef struct packed {
		logic [1:0] operation;
		logic       found;
		logic       full;
	} stat_t;

endpackage

// ----- hdl/psq_ctrl.sv -----
// Controller state machine of the priority sorted wait queue.
// Depends on psq_pkg; drives the commands of psq_datapath from its status.
module psq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  psq_pkg::stat_t stat,
	output psq_pkg::cmd_t  cmd,
	output logic           busy,
	output logic           done
);

	psq_pkg::state_t state_q;
	psq_pkg::state_t state_d;
	logic            done_q;
	logic            finish;

	always_comb begin
		state_d = state_q;
		case (state_q)
			psq_pkg::ST_IDLE: begin
				if (start) begin
					state_d = psq_pkg::ST_EXEC;
				end
			end
			psq_pkg::ST_EXEC: begin
				if (stat.operation == psq_pkg::OP_REQUEUE && stat.found) begin
					state_d = psq_pkg::ST_REINS;
				end else begin
					state_d = psq_pkg::ST_IDLE;
				end
			end
			psq_pkg::ST_REINS: begin
				state_d = psq_pkg::ST_IDLE;
			end
			default: begin
				state_d = psq_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd    = '0;
		finish = 1'b0;
		case (state_q)
			psq_pkg::ST_IDLE: begin
				cmd.load = start;
			end
			psq_pkg::ST_EXEC: begin
				cmd.status = psq_pkg::STATUS_OK;
				case (stat.operation)
					psq_pkg::OP_ADD: begin
						if (stat.found) begin
							cmd.status = psq_pkg::STATUS_ALREADY;
						end else if (stat.full) begin
							cmd.status = psq_pkg::STATUS_FULL;
						end else begin
							cmd.insert = 1'b1;
						end
						finish = 1'b1;
					end
					psq_pkg::OP_REMOVE: begin
						if (stat.found) begin
							cmd.remove = 1'b1;
						end else begin
							cmd.status = psq_pkg::STATUS_NOT_QUEUED;
						end
						finish = 1'b1;
					end
					psq_pkg::OP_REQUEUE: begin
						if (stat.found) begin
							cmd.remove = 1'b1;
						end else begin
							cmd.status = psq_pkg::STATUS_NOT_QUEUED;
							finish     = 1'b1;
						end
					end
					default: begin
						finish = 1'b1;
					end
				endcase
				cmd.set_status = finish;
			end
			psq_pkg::ST_REINS: begin
				cmd.insert     = 1'b1;
				cmd.status     = psq_pkg::STATUS_OK;
				cmd.set_status = 1'b1;
				finish         = 1'b1;
			end
			default: begin
				finish = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psq_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
		end
	end

	assign busy = (state_q != psq_pkg::ST_IDLE);
	assign done = done_q;

endmodule

// ----- hdl/psq_datapath.sv -----
// Datapath of the priority sorted wait queue: a chain of slot cells kept in queue order.
// Depends on psq_pkg; is commanded by psq_ctrl.
module psq_datapath #(
	parameter int QUEUE_DEPTH    = psq_pkg::DEF_QUEUE_DEPTH,
	parameter int THREAD_ID_BITS = psq_pkg::DEF_THREAD_ID_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  psq_pkg::req_t  request,
	input  psq_pkg::cmd_t  cmd,
	output psq_pkg::stat_t stat,
	output psq_pkg::rsp_t  result
);

	localparam int CountW = $clog2(QUEUE_DEPTH + 1);

	psq_pkg::req_t             req_q;
	psq_pkg::status_t          status_q;
	logic [CountW-1:0]         count_q;
	logic [THREAD_ID_BITS-1:0] slot_thread_q [QUEUE_DEPTH];
	logic [7:0]                slot_prio_q   [QUEUE_DEPTH];

	logic [THREAD_ID_BITS-1:0] tid;
	logic [QUEUE_DEPTH-1:0]    match;
	logic [QUEUE_DEPTH-1:0]    shift_up;
	logic [QUEUE_DEPTH-1:0]    keep;

	assign tid = THREAD_ID_BITS'(req_q.thread_id);

	// Each cell compares its own entry; the chained OR marks the cells at and behind a match.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic occupied;
		assign occupied = (CountW'(i) < count_q);
		assign match[i] = occupied && (slot_thread_q[i] == tid);
		assign keep[i]  = occupied && (slot_prio_q[i] >= req_q.priority_req);
		if (i == 0) begin : g_first
			assign shift_up[i] = match[i];
		end else begin : g_rest
			assign shift_up[i] = shift_up[i-1] | match[i];
		end

		always_ff @(posedge clk) begin
			if (cmd.remove) begin
				if (shift_up[i] && i + 1 < QUEUE_DEPTH) begin
					slot_thread_q[i] <= slot_thread_q[(i + 1) % QUEUE_DEPTH];
					slot_prio_q[i]   <= slot_prio_q[(i + 1) % QUEUE_DEPTH];
				end
			end else if (cmd.insert && !keep[i]) begin
				if (i == 0 || keep[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH]) begin
					slot_thread_q[i] <= tid;
					slot_prio_q[i]   <= req_q.priority_req;
				end else begin
					slot_thread_q[i] <= slot_thread_q[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
					slot_prio_q[i]   <= slot_prio_q[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.remove) begin
			count_q <= count_q - CountW'(1);
		end else if (cmd.insert) begin
			count_q <= count_q + CountW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= request;
		end
		if (cmd.set_status) begin
			status_q <= cmd.status;
		end
	end

	assign stat.operation = req_q.operation;
	assign stat.found     = |match;
	assign stat.full      = (count_q == CountW'(QUEUE_DEPTH));

	assign result.status        = status_q;
	assign result.head_valid    = (count_q != '0);
	assign result.head_thread   = result.head_valid ? 8'(slot_thread_q[0]) : 8'd0;
	assign result.head_priority = result.head_valid ? slot_prio_q[0] : 8'd0;
	assign result.entry_count   = 5'(count_q);

endmodule

// ----- hdl/priority_sorted_wait_queue.sv -----
// Top level of the priority sorted wait queue.
// Depends on psq_pkg, psq_ctrl and psq_datapath.

// A request is taken when start is high while busy is low. Add, remove and a requeue of a
// thread that is not queued pass through the execute state before the registered done
// strobe, a requeue of a queued thread also through the reinsert state, because its removal
// and reinsertion each pass once through the slot cell chain. The result stands on the
// result ports for the single cycle that done marks and cannot be held off, so the receiver
// must take it then; busy is already low in that cycle and a new request may be accepted
// alongside it. The queue comes out of reset empty.
module priority_sorted_wait_queue #(
	parameter int QUEUE_DEPTH    = psq_pkg::DEF_QUEUE_DEPTH,
	parameter int THREAD_ID_BITS = psq_pkg::DEF_THREAD_ID_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  psq_pkg::req_t request,
	output logic          done,
	output psq_pkg::rsp_t result
);

	psq_pkg::cmd_t  cmd;
	psq_pkg::stat_t stat;

	psq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	psq_datapath #(
		.QUEUE_DEPTH    (QUEUE_DEPTH),
		.THREAD_ID_BITS (THREAD_ID_BITS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.stat    (stat),
		.result  (result)
	);

endmodule
